// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication assertion, disabled during reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/lbcid_pkg.sv -----
// ----------------------------------------------------------------------------
// lbcid_pkg
// Types, constants and AES helper functions for the CID codec.
// ----------------------------------------------------------------------------
package lbcid_pkg;

    localparam int unsigned ROUNDS      = 10;
    localparam int unsigned BLK_W       = 128;
    localparam int unsigned ADDR_W      = 5;
    localparam logic [3:0]  SID_BYTES_RST = 4'd8;

    // Register byte addresses.
    localparam logic [ADDR_W-1:0] REG_KEY_HIGH  = 5'h00;
    localparam logic [ADDR_W-1:0] REG_KEY_LOW   = 5'h08;
    localparam logic [ADDR_W-1:0] REG_NODE_ID   = 5'h10;
    localparam logic [ADDR_W-1:0] REG_SID_BYTES = 5'h18;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef logic [BLK_W-1:0] blk_t;

    // Side-band carried through the round pipeline with each block.
    typedef struct packed {
        logic       req;
        logic [3:0] sid_len;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits in bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_b(input blk_t s, input int i);
        return s[BLK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rd);
        logic [7:0] r;
        r = 8'h01;
        for (int k = 1; k < 11; k++) begin
            if (k < int'(rd)) r = xtime(r);
        end
        return r;
    endfunction

    // Next round key from the previous one.
    function automatic blk_t key_next(input blk_t k, input logic [7:0] rc);
        blk_t n;
        logic [31:0] t;
        t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        n[127:96] = k[127:96] ^ t;
        n[95:64]  = k[95:64] ^ n[127:96];
        n[63:32]  = k[63:32] ^ n[95:64];
        n[31:0]   = k[31:0] ^ n[63:32];
        return n;
    endfunction

    // Previous round key from the next one.
    function automatic blk_t key_prev(input blk_t n, input logic [7:0] rc);
        blk_t k;
        logic [31:0] t;
        k[31:0]   = n[31:0] ^ n[63:32];
        k[63:32]  = n[63:32] ^ n[95:64];
        k[95:64]  = n[95:64] ^ n[127:96];
        t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        k[127:96] = n[127:96] ^ t;
        return k;
    endfunction

    function automatic blk_t enc_round(input blk_t s, input blk_t k, input logic last);
        blk_t t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLK_W-1-8*(r+4*c) -: 8] = sbox(get_b(s, r + 4*((c + r) % 4)));
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1);
                a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
                al = a0 ^ a1 ^ a2 ^ a3;
                t[BLK_W-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                         a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
            end
        end
        return t ^ k;
    endfunction

    // Inverse round: inverse shift and substitution, key, then inverse mix.
    function automatic blk_t dec_round(input blk_t s, input blk_t k, input logic last);
        blk_t t;
        logic [7:0] a0, a1, a2, a3, x2 [4], x4 [4], x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLK_W-1-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(get_b(s, r + 4*c));
            end
        end
        t = t ^ k;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1);
                a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
                x2[0] = xtime(a0); x2[1] = xtime(a1); x2[2] = xtime(a2); x2[3] = xtime(a3);
                for (int j = 0; j < 4; j++) begin
                    x4[j] = xtime(x2[j]);
                    x8[j] = xtime(x4[j]);
                end
                // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1.
                t[BLK_W-1-32*c -: 32] = {
                    (x8[0]^x4[0]^x2[0]) ^ (x8[1]^x2[1]^a1) ^ (x8[2]^x4[2]^a2) ^ (x8[3]^a3),
                    (x8[0]^a0) ^ (x8[1]^x4[1]^x2[1]) ^ (x8[2]^x2[2]^a2) ^ (x8[3]^x4[3]^a3),
                    (x8[0]^x4[0]^a0) ^ (x8[1]^a1) ^ (x8[2]^x4[2]^x2[2]) ^ (x8[3]^x2[3]^a3),
                    (x8[0]^x2[0]^a0) ^ (x8[1]^x4[1]^a1) ^ (x8[2]^a2) ^ (x8[3]^x4[3]^x2[3])};
            end
        end
        return t;
    endfunction

endpackage

// ----- hw/rtl/lb_cid_aes_block_codec_top.sv -----
// A new 16-byte request is taken every cycle while the result path is not
// stalled and the key is ready; each result passes an input stage, ten AES
// round stages (each with its own key schedule step) and an output register.
// The pipeline halts as a whole while the result is not taken. After reset and
// after each key write, s_tready stays low while the last round key for
// decryption is derived.
// ----------------------------------------------------------------------------
// lb_cid_aes_block_codec_top
// Load-balancer CID encoder and decoder built on a pipelined AES-128.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lb_cid_aes_block_codec_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // block_high [63:0], block_low [127:64]
    input  logic         s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata   // cid_high, cid_low, decoded_server_id
);
    import lbcid_pkg::*;

    blk_t        key0, key10;
    logic        key_rdy;
    logic [63:0] sid;
    logic [3:0]  sid_bytes;
    logic        adv;

    lbcid_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .key0, .key10, .key_ready(key_rdy), .node_id(sid), .sid_bytes
    );

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && key_rdy;

    // Input stage: build the plaintext for encode requests and apply the first round key of the chosen direction.
    logic [3:0] len;
    blk_t pt, in_blk;
    assign len    = (sid_bytes == 4'd0) ? 4'd1 : sid_bytes;
    assign in_blk = {s_tdata[63:0], s_tdata[127:64]};
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (i < int'(len)) begin
                if (int'(len) - 1 - i < 8) begin
                    pt[BLK_W-1-8*i -: 8] = sid[8*(int'(len)-1-i) +: 8];
                end else begin
                    pt[BLK_W-1-8*i -: 8] = 8'h00;
                end
            end else begin
                pt[BLK_W-1-8*i -: 8] = in_blk[BLK_W-1-8*i -: 8];
            end
        end
    end

    logic  v_st [ROUNDS+1];
    blk_t  s_st [ROUNDS+1];
    blk_t  e_st [ROUNDS+1];
    blk_t  d_st [ROUNDS+1];
    side_t x_st [ROUNDS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_st[0] <= 1'b0;
        end else if (adv) begin
            v_st[0] <= s_tvalid && key_rdy;
        end
        if (adv) begin
            s_st[0] <= (s_tuser == REQ_DECODE) ? (in_blk ^ key10) : (pt ^ key0);
            e_st[0] <= key0;
            d_st[0] <= key10;
            x_st[0] <= '{req: s_tuser, sid_len: len};
        end
    end

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_rd
        lbcid_round #(.RD(4'(g))) u_rd (
            .aclk, .aresetn, .adv,
            .vld_in(v_st[g-1]), .st_in(s_st[g-1]), .ek_in(e_st[g-1]),
            .dk_in(d_st[g-1]), .sd_in(x_st[g-1]),
            .vld_out(v_st[g]), .st_out(s_st[g]), .ek_out(e_st[g]),
            .dk_out(d_st[g]), .sd_out(x_st[g])
        );
    end

    // Output stage: form the result fields.
    logic [63:0] dec_sid;
    always_comb begin
        dec_sid = '0;
        for (int i = 0; i < 15; i++) begin
            if (i < int'(x_st[ROUNDS].sid_len)) begin
                dec_sid = {dec_sid[55:0], s_st[ROUNDS][BLK_W-1-8*i -: 8]};
            end
        end
    end

    logic         mv_reg;
    logic [191:0] md_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (adv) begin
            mv_reg <= v_st[ROUNDS];
        end
        if (adv) begin
            if (x_st[ROUNDS].req == REQ_DECODE) begin
                md_reg <= {dec_sid, 128'd0};
            end else begin
                md_reg <= {64'd0, s_st[ROUNDS][63:0], s_st[ROUNDS][127:64]};
            end
        end
    end
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    `ASSERT_CLK(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
    `ASSERT_CLK(a_rdy, aclk, aresetn, s_tready |-> (!m_tvalid || m_tready), "ready mismatch")
    `ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule

// ----- hw/rtl/lbcid_regs.sv -----
// ----------------------------------------------------------------------------
// lbcid_regs
// Configuration registers behind the APB port, with the key schedule ends.
// The last round key is derived after reset and after a key write;
// key_ready stays low meanwhile. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lbcid_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbcid_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output lbcid_pkg::blk_t               key0,
    output lbcid_pkg::blk_t               key10,
    output logic                          key_ready,
    output logic [63:0]                   node_id,
    output logic [3:0]                    sid_bytes
);
    import lbcid_pkg::*;

    logic [63:0] key_high_reg, key_low_reg, node_id_reg;
    logic [3:0]  sid_bytes_reg;
    blk_t        sched_reg, sched_next;
    logic [3:0]  rd_reg, rd_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            node_id_reg   <= '0;
            sid_bytes_reg <= SID_BYTES_RST;
        end else if (wr_en) begin
            unique case (paddr)
                REG_KEY_HIGH:  key_high_reg  <= pwdata;
                REG_KEY_LOW:   key_low_reg   <= pwdata;
                REG_NODE_ID:   node_id_reg   <= pwdata;
                REG_SID_BYTES: sid_bytes_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Walk the schedule to the last round key, one round a cycle.
    always_comb begin
        rd_next    = rd_reg;
        sched_next = sched_reg;
        if (wr_en && (paddr == REG_KEY_HIGH || paddr == REG_KEY_LOW)) begin
            rd_next = 4'd0;
        end else if (rd_reg == 4'd0) begin
            sched_next = {key_high_reg, key_low_reg};
            rd_next    = 4'd1;
        end else if (rd_reg <= 4'(ROUNDS)) begin
            sched_next = key_next(sched_reg, rcon(rd_reg));
            rd_next    = rd_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 4'd0;
        end else begin
            rd_reg <= rd_next;
        end
        sched_reg <= sched_next;
    end

    always_comb begin
        unique case (paddr)
            REG_KEY_HIGH:  prdata = key_high_reg;
            REG_KEY_LOW:   prdata = key_low_reg;
            REG_NODE_ID:   prdata = node_id_reg;
            REG_SID_BYTES: prdata = {60'd0, sid_bytes_reg};
            default:       prdata = '0;
        endcase
    end

    assign key0      = {key_high_reg, key_low_reg};
    assign key10     = sched_reg;
    assign key_ready = (rd_reg > 4'(ROUNDS));
    assign node_id   = node_id_reg;
    assign sid_bytes = sid_bytes_reg;
endmodule

// ----- hw/rtl/lbcid_round.sv -----
// ----------------------------------------------------------------------------
// lbcid_round
// One registered AES round stage, encrypt or decrypt per item, with its own
// round key carried alongside (forward or backward schedule step).
// ----------------------------------------------------------------------------
module lbcid_round #(
    parameter logic [3:0] RD = 4'd1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              vld_in,
    input  lbcid_pkg::blk_t   st_in,
    input  lbcid_pkg::blk_t   ek_in,
    input  lbcid_pkg::blk_t   dk_in,
    input  lbcid_pkg::side_t  sd_in,
    output logic              vld_out,
    output lbcid_pkg::blk_t   st_out,
    output lbcid_pkg::blk_t   ek_out,
    output lbcid_pkg::blk_t   dk_out,
    output lbcid_pkg::side_t  sd_out
);
    import lbcid_pkg::*;

    logic vld_reg;
    blk_t st_reg, ek_reg, dk_reg, ek_n, dk_n, st_next;
    side_t sd_reg;

    // Encrypt round RD uses key RD; decrypt step RD uses key 10-RD.
    assign ek_n = key_next(ek_in, rcon(RD));
    assign dk_n = key_prev(dk_in, rcon(4'(ROUNDS) + 4'd1 - RD));
    assign st_next = (sd_in.req == REQ_DECODE)
                   ? dec_round(st_in, dk_n, RD == 4'(ROUNDS))
                   : enc_round(st_in, ek_n, RD == 4'(ROUNDS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= vld_in;
        end
        if (adv) begin
            st_reg <= st_next;
            ek_reg <= ek_n;
            dk_reg <= dk_n;
            sd_reg <= sd_in;
        end
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;
    assign ek_out  = ek_reg;
    assign dk_out  = dk_reg;
    assign sd_out  = sd_reg;
endmodule
